[sv/txu_pkg.sv]
`timescale 1ns / 1ps
package txu_pkg;

  localparam int unsigned RegIdxW  = 6;   // widest register index (64 regs)
  localparam int unsigned RamIdxW  = 16;  // widest RAM index (65536 words)
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_DIV    = 4'd2,
    OP_MUL    = 4'd3,
    OP_MOV    = 4'd4,
    OP_LOADI  = 4'd5,
    OP_LOADM  = 4'd6,
    OP_STOREM = 4'd7,
    OP_BRZ    = 4'd8,
    OP_BRLZ   = 4'd9,
    OP_BRNZ   = 4'd10,
    OP_IBRZ   = 4'd11,
    OP_BRGZ   = 4'd12,
    OP_WRITE  = 4'd13,
    OP_READ   = 4'd14,
    OP_EXIT   = 4'd15
  } txu_opcode_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_HI,
    F_LO,
    F_PUSH
  } txu_fstate_e;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_EXEC,
    B_MUL,
    B_DIV,
    B_WB
  } txu_bstate_e;

  typedef struct packed {
    logic        [3:0]  req_type;
    logic        [2:0]  dest_index;
    logic signed [15:0] second_operand;
    logic        [15:0] instr_address;
    logic signed [63:0] read_value;
  } txu_req_t;

  typedef struct packed {
    logic               branch_taken;
    logic        [15:0] branch_target;
    logic               write_valid;
    logic signed [63:0] write_value;
    logic               halt;
    logic               div_by_zero;
  } txu_res_t;

  // classified instruction, indices already reduced
  typedef struct packed {
    txu_opcode_e         opcode;
    logic [RegIdxW-1:0]  d_idx;
    logic [RegIdxW-1:0]  s_idx;
    logic [RamIdxW-1:0]  ram_addr;
    logic [15:0]         offset;
    logic [15:0]         pc;
    logic [63:0]         read_value;
  } txu_op_t;

endpackage

[sv/txu_front.sv]
`timescale 1ns / 1ps
module txu_front import txu_pkg::*; #(
  parameter int unsigned NUM_REGS  = 8,
  parameter int unsigned RAM_WORDS = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     enable_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  txu_req_t in_data_i,
  output logic     push_o,
  input  logic     push_ready_i,
  output txu_op_t  push_data_o
);

  localparam int unsigned SW = $clog2(NUM_REGS) + 1;
  localparam int unsigned AW = $clog2(RAM_WORDS) + 1;

  txu_fstate_e state_q, state_d;
  txu_req_t    req_q, req_d;
  logic [SW-1:0] srem_q, srem_d;
  logic [AW-1:0] arem_q, arem_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    srem_q <= srem_d;
    arem_q <= arem_d;
  end

  // one byte of the remainder reduction per cycle, high byte first
  always_comb begin
    logic [7:0]    bits;
    logic [SW-1:0] sr;
    logic [AW-1:0] ar;
    logic [SW-1:0] dr;
    state_d     = state_q;
    req_d       = req_q;
    srem_d      = srem_q;
    arem_d      = arem_q;
    in_ready_o  = 1'b0;
    push_o      = 1'b0;
    bits = (state_q == F_HI) ? req_q.second_operand[15:8] : req_q.second_operand[7:0];
    sr   = (state_q == F_HI) ? '0 : srem_q;
    ar   = (state_q == F_HI) ? '0 : arem_q;
    for (int i = 7; i >= 0; i--) begin
      sr = {sr[SW-2:0], bits[i]};
      if (sr >= SW'(NUM_REGS)) sr = sr - SW'(NUM_REGS);
      ar = {ar[AW-2:0], bits[i]};
      if (ar >= AW'(RAM_WORDS)) ar = ar - AW'(RAM_WORDS);
    end
    dr = '0;
    for (int i = 2; i >= 0; i--) begin
      dr = {dr[SW-2:0], req_q.dest_index[i]};
      if (dr >= SW'(NUM_REGS)) dr = dr - SW'(NUM_REGS);
    end

    push_data_o.opcode     = txu_opcode_e'(req_q.req_type);
    push_data_o.d_idx      = RegIdxW'(dr);
    push_data_o.s_idx      = RegIdxW'(srem_q);
    push_data_o.ram_addr   = RamIdxW'(arem_q);
    push_data_o.offset     = req_q.second_operand;
    push_data_o.pc         = req_q.instr_address;
    push_data_o.read_value = req_q.read_value;

    case (state_q)
      F_IDLE: begin
        in_ready_o = enable_i;
        if (in_valid_i && enable_i) begin
          req_d   = in_data_i;
          state_d = F_HI;
        end
      end
      F_HI: begin
        srem_d  = sr;
        arem_d  = ar;
        state_d = F_LO;
      end
      F_LO: begin
        srem_d  = sr;
        arem_d  = ar;
        state_d = F_PUSH;
      end
      F_PUSH: begin
        push_o = 1'b1;
        if (push_ready_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

endmodule

[sv/txu_queue.sv]
`timescale 1ns / 1ps
module txu_queue import txu_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  output logic    push_ready_o,
  input  txu_op_t push_data_i,
  output logic    pop_valid_o,
  input  logic    pop_i,
  output txu_op_t pop_data_o
);

  localparam int unsigned PW = $clog2(QueueDepth);

  txu_op_t       mem_q [QueueDepth];
  logic [PW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [PW:0]   cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign push_ready_o = (cnt_q != (PW+1)'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wptr_d = do_push ? wptr_q + PW'(1) : wptr_q;
    rptr_d = do_pop ? rptr_q + PW'(1) : rptr_q;
    cnt_d  = cnt_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= push_data_i;
  end

endmodule

[sv/txu_divider.sv]
`timescale 1ns / 1ps
module txu_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [63:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quotient_o
);

  // restoring unsigned divide, one quotient bit per cycle
  logic        busy_q, busy_d, done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [64:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d, dvs_q, dvs_d;

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_comb begin
    logic [64:0] sh;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    sh     = {rem_q[63:0], quo_q[63]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (sh >= {1'b0, dvs_q}) begin
        rem_d = sh - {1'b0, dvs_q};
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = sh;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

endmodule

[sv/txu_back.sv]
`timescale 1ns / 1ps
module txu_back import txu_pkg::*; #(
  parameter int unsigned NUM_REGS  = 8,
  parameter int unsigned RAM_WORDS = 256,
  parameter int unsigned PC_BITS   = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  output logic     ready_o,
  input  logic     q_valid_i,
  output logic     q_pop_o,
  input  txu_op_t  q_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output txu_res_t out_data_o
);

  localparam int unsigned RIW = $clog2(NUM_REGS);
  localparam int unsigned AIW = $clog2(RAM_WORDS);
  localparam logic [15:0] PcMask =
    (PC_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << PC_BITS) - 32'd1);

  txu_bstate_e state_q, state_d;
  txu_op_t     op_q, op_d;
  txu_res_t    res_q, res_d, out_q, out_d;
  logic        out_valid_q, out_valid_d;
  logic [NUM_REGS-1:0] rf_vld_q, rf_vld_d;
  logic [AIW-1:0] clr_q, clr_d;
  logic [63:0] rx_q, ry_q, ram_q;
  logic        rxv_q, ryv_q;
  logic        wb_en_q, wb_en_d, div_neg_q, div_neg_d;
  logic [63:0] wb_val_q, wb_val_d, acc_q, acc_d;
  logic [1:0]  mcnt_q, mcnt_d;
  logic        rd_en, rf_we, ram_we, div_start, div_done;
  logic [AIW-1:0] ram_wa;
  logic [63:0] ram_wd, rx, ry, quo;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  logic [63:0] rf_mem  [NUM_REGS];
  logic [63:0] ram_mem [RAM_WORDS];

  assign ready_o     = (state_q != B_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign rx = rxv_q ? rx_q : '0;
  assign ry = ryv_q ? ry_q : '0;

  txu_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rx[63] ? -rx : rx),
    .divisor_i  (ry[63] ? -ry : ry),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // 32x32 partial products, low word of the 64-bit product only
  always_comb begin
    case (mcnt_q)
      2'd0:    begin mul_a = rx[31:0];  mul_b = ry[31:0];  end
      2'd1:    begin mul_a = rx[31:0];  mul_b = ry[63:32]; end
      default: begin mul_a = rx[63:32]; mul_b = ry[31:0];  end
    endcase
    prod = {32'd0, mul_a} * {32'd0, mul_b};
  end

  always_comb begin
    logic [15:0] off_tgt, ind_tgt;
    state_d     = state_q;
    op_d        = op_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rf_vld_d    = rf_vld_q;
    clr_d       = clr_q;
    wb_en_d     = wb_en_q;
    wb_val_d    = wb_val_q;
    acc_d       = acc_q;
    mcnt_d      = mcnt_q;
    div_neg_d   = div_neg_q;
    rd_en       = 1'b0;
    rf_we       = 1'b0;
    ram_we      = 1'b0;
    ram_wa      = op_q.ram_addr[AIW-1:0];
    ram_wd      = rx;
    div_start   = 1'b0;
    q_pop_o     = 1'b0;
    off_tgt     = (op_q.pc + op_q.offset) & PcMask;
    ind_tgt     = (op_q.pc + ram_q[15:0]) & PcMask;

    case (state_q)
      B_CLEAR: begin
        ram_we = 1'b1;
        ram_wa = clr_q;
        ram_wd = '0;
        clr_d  = clr_q + AIW'(1);
        if (clr_q == AIW'(RAM_WORDS - 1)) state_d = B_IDLE;
      end
      B_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          rd_en   = 1'b1;
          op_d    = q_data_i;
          state_d = B_EXEC;
        end
      end
      B_EXEC: begin
        res_d   = '0;
        wb_en_d = 1'b0;
        state_d = B_WB;
        case (op_q.opcode)
          OP_ADD:   begin wb_en_d = 1'b1; wb_val_d = rx + ry; end
          OP_SUB:   begin wb_en_d = 1'b1; wb_val_d = rx - ry; end
          OP_MOV:   begin wb_en_d = 1'b1; wb_val_d = ry; end
          OP_LOADI: begin wb_en_d = 1'b1; wb_val_d = {{48{op_q.offset[15]}}, op_q.offset}; end
          OP_LOADM: begin wb_en_d = 1'b1; wb_val_d = ram_q; end
          OP_READ:  begin wb_en_d = 1'b1; wb_val_d = op_q.read_value; end
          OP_STOREM: ram_we = 1'b1;
          OP_BRZ:   res_d.branch_taken = (rx == '0);
          OP_BRLZ:  res_d.branch_taken = rx[63];
          OP_BRNZ:  res_d.branch_taken = (rx != '0);
          OP_BRGZ:  res_d.branch_taken = (rx != '0) && !rx[63];
          OP_IBRZ:  res_d.branch_taken = (rx == '0);
          OP_WRITE: begin res_d.write_valid = 1'b1; res_d.write_value = rx; end
          OP_MUL: begin
            mcnt_d  = 2'd0;
            state_d = B_MUL;
          end
          OP_DIV: begin
            if (ry == '0) begin
              res_d.div_by_zero = 1'b1;
            end else begin
              div_start = 1'b1;
              div_neg_d = rx[63] ^ ry[63];
              state_d   = B_DIV;
            end
          end
          default:  res_d.halt = 1'b1;
        endcase
        if (res_d.branch_taken)
          res_d.branch_target = (op_q.opcode == OP_IBRZ) ? ind_tgt : off_tgt;
      end
      B_MUL: begin
        acc_d  = (mcnt_q == 2'd0) ? prod : acc_q + {prod[31:0], 32'd0};
        mcnt_d = mcnt_q + 2'd1;
        if (mcnt_q == 2'd2) begin
          wb_en_d  = 1'b1;
          wb_val_d = acc_d;
          state_d  = B_WB;
        end
      end
      B_DIV: begin
        if (div_done) begin
          wb_en_d  = 1'b1;
          wb_val_d = div_neg_q ? -quo : quo;
          state_d  = B_WB;
        end
      end
      B_WB: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          rf_we       = wb_en_q;
          if (wb_en_q) rf_vld_d[op_q.d_idx[RIW-1:0]] = 1'b1;
          state_d     = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      out_valid_q <= 1'b0;
      rf_vld_q    <= '0;
      clr_q       <= '0;
      mcnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      rf_vld_q    <= rf_vld_d;
      clr_q       <= clr_d;
      mcnt_q      <= mcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    res_q     <= res_d;
    out_q     <= out_d;
    wb_en_q   <= wb_en_d;
    wb_val_q  <= wb_val_d;
    acc_q     <= acc_d;
    div_neg_q <= div_neg_d;
  end

  // register file: two registered reads, one write
  always_ff @(posedge clk_i) begin
    if (rf_we) rf_mem[op_q.d_idx[RIW-1:0]] <= wb_val_q;
    if (rd_en) begin
      rx_q  <= rf_mem[q_data_i.d_idx[RIW-1:0]];
      ry_q  <= rf_mem[q_data_i.s_idx[RIW-1:0]];
      rxv_q <= rf_vld_q[q_data_i.d_idx[RIW-1:0]];
      ryv_q <= rf_vld_q[q_data_i.s_idx[RIW-1:0]];
    end
  end

  // data RAM: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (ram_we) ram_mem[ram_wa] <= ram_wd;
    if (rd_en) ram_q <= ram_mem[q_data_i.ram_addr[AIW-1:0]];
  end

endmodule

[sv/tiny_isa_execute_unit.sv]
`timescale 1ns / 1ps
// Channel | Direction | Handshake                    | Payload
// in      | input     | in_valid_i / in_ready_o      | in_data_i  (txu_req_t)
// out     | output    | out_valid_o / out_ready_i    | out_data_o (txu_res_t)
//
// Front end takes one transfer at a time and accepts the next only after
// its push: accept, index reduction in F_HI then F_LO (one byte of
// second_operand each), push into a 2-entry queue. Back end: queue pop
// with registered RF/RAM reads, execute, writeback and output load; mul on
// a shared 32x32 multiplier (three partial products), div on a divider
// making one quotient bit per cycle. After reset the data RAM is cleared one
// word a cycle, in_ready_o low meanwhile. The output register holds a result
// under a stall while the front end and queue keep taking transfers.
module tiny_isa_execute_unit import txu_pkg::*; #(
  parameter int unsigned NUM_REGS  = 8,
  parameter int unsigned RAM_WORDS = 256,
  parameter int unsigned PC_BITS   = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  txu_req_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output txu_res_t out_data_o
);

  logic    push, push_ready, pop_valid, pop, back_ready;
  txu_op_t push_data, pop_data;

  // classify and reduce register / RAM indices
  txu_front #(
    .NUM_REGS  (NUM_REGS),
    .RAM_WORDS (RAM_WORDS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .enable_i     (back_ready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // decouples front and back stalls
  txu_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (pop_data)
  );

  // register file, data RAM, ALU, multiplier, divider, output register
  txu_back #(
    .NUM_REGS  (NUM_REGS),
    .RAM_WORDS (RAM_WORDS),
    .PC_BITS   (PC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ready_o     (back_ready),
    .q_valid_i   (pop_valid),
    .q_pop_o     (pop),
    .q_data_i    (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
